// File: rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Holds the item formats, the request and status codes, the controller
// states and the command group that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_REAR  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_REAR   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_REAR  = 3'd5
  } dq_req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } dq_status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } dq_state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] push_value;
  } dq_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [4:0]  entry_total;
    logic        is_empty;
  } dq_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // carry out the captured request
  } dq_cmd_t;

endpackage

// File: rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl: request sequencer
// Steps each accepted item through capture, execution and the result cycle.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output logic           done_o,
  output dq_pkg::dq_cmd_t cmd_o
);
  import dq_pkg::*;

  dq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: state_d = S_RESP;
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    done_o     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      S_EXEC: cmd_o.exec = 1'b1;
      S_RESP: done_o = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// File: rtl/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath: ring buffer storage, pointers and count
// Holds the entry memory, the front and rear slot pointers and the entry
// count, and forms the result of each request.
// ----------------------------------------------------------------------------
module dq_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dq_pkg::dq_cmd_t cmd_i,
  input  dq_pkg::dq_req_t req_i,
  output dq_pkg::dq_res_t res_o
);
  import dq_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  dq_req_t               req_q;
  logic [PTR_W-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  dq_status_e            status_q, status_d;
  logic                  rd_hit_q;
  logic [DATA_WIDTH-1:0] rd_data_q;

  logic                  full, empty;
  logic                  wr_en, rd_en;
  logic [PTR_W-1:0]      wr_addr, rd_addr;
  logic [PTR_W-1:0]      head_nx, head_pv, tail_nx, tail_pv;

  function automatic logic [PTR_W-1:0] slot_next(input logic [PTR_W-1:0] s);
    return (s == PTR_W'(DEPTH - 1)) ? '0 : s + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] slot_prev(input logic [PTR_W-1:0] s);
    return (s == '0) ? PTR_W'(DEPTH - 1) : s - PTR_W'(1);
  endfunction

  assign full    = (cnt_q == CNT_W'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign head_nx = slot_next(head_q);
  assign head_pv = slot_prev(head_q);
  assign tail_nx = slot_next(tail_q);
  assign tail_pv = slot_prev(tail_q);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    status_d = STAT_OK;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = tail_q;
    rd_addr  = head_q;
    unique case (dq_req_e'(req_q.req_type))
      REQ_PUSH_FRONT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          head_d  = head_pv;
          wr_addr = head_pv;
          wr_en   = 1'b1;
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      REQ_PUSH_REAR: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          wr_addr = tail_q;
          wr_en   = 1'b1;
          tail_d  = tail_nx;
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          rd_addr = head_q;
          rd_en   = 1'b1;
          head_d  = head_nx;
          cnt_d   = cnt_q - CNT_W'(1);
        end
      end
      REQ_POP_REAR: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          tail_d  = tail_pv;
          rd_addr = tail_pv;
          rd_en   = 1'b1;
          cnt_d   = cnt_q - CNT_W'(1);
        end
      end
      REQ_PEEK_FRONT: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          rd_addr = head_q;
          rd_en   = 1'b1;
        end
      end
      REQ_PEEK_REAR: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          rd_addr = tail_pv;
          rd_en   = 1'b1;
        end
      end
      default: status_d = STAT_OK;
    endcase
  end

  // Request capture; payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      status_q <= STAT_OK;
      rd_hit_q <= 1'b0;
    end else if (cmd_i.exec) begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      rd_hit_q <= rd_en;
    end
  end

  // Entry memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[wr_addr] <= req_q.push_value[DATA_WIDTH-1:0];
    end
    if (cmd_i.exec && rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    res_o.status      = status_q;
    res_o.read_value  = rd_hit_q ? 32'(rd_data_q) : '0;
    res_o.entry_total = 5'(cnt_q);
    res_o.is_empty    = (cnt_q == '0);
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CNT_W'(DEPTH)) |-> head_q == tail_q)
    else $error("pointers disagree with empty or full count");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(cnt_q) && $stable(head_q) && $stable(tail_q))
    else $error("queue state moved outside an execute cycle");

endmodule

// File: rtl/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded double-ended queue on a ring buffer
// Order: an accepted item is captured, the execute step registers pointers,
//   count, status and the memory read, and the result shows on res_o with
//   done_o in the result state. A new item is taken only back in idle,
//   after the capture, execute and result steps of the last one.
// Reset: rst_ni clears pointers, count and controller at once; no clearing
//   pass runs, and the first item may be started right after reset.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  dq_pkg::dq_req_t req_i,
  output logic            done_o,
  output dq_pkg::dq_res_t res_o
);
  import dq_pkg::*;

  // The controller walks each item through three states: in idle it takes
  // the item when start is high, in execute the datapath updates pointers,
  // count and memory, and in the result state the strobe marks the result.
  dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // The datapath holds the entries and forms the status, the word read,
  // and the count after each request. The result holds until the next execute
  // step, and the receiver takes it while the strobe is high, without a handshake.
  dq_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .res_o  (res_o)
  );

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for double_ended_queue_core
// Sends requests through the start/busy handshake and predicts every result
// with a ring-buffer model of its own. Each result strobed on done_o is
// compared field by field with the oldest prediction. A short table of
// directed requests comes first, then about two thousand random requests
// in runs of randomly chosen fill, drain or mixed shape so that the queue
// reaches both full and empty many times.
// ----------------------------------------------------------------------------
module testbench;
  import dq_pkg::*;

  // Request codes that the block must ignore.
  localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned TAIL_CYCLES  = 12;
  localparam int unsigned REPORT_LIMIT = 10;

  // Shapes of the random runs.
  localparam int unsigned MODE_FILL  = 0;
  localparam int unsigned MODE_DRAIN = 1;
  localparam int unsigned MODE_MIX   = 2;

  // Pushes come first in this list; the four reads follow.
  localparam dq_req_e ALL_REQS [6] = '{REQ_PUSH_FRONT, REQ_PUSH_REAR, REQ_POP_FRONT,
                                       REQ_POP_REAR, REQ_PEEK_FRONT, REQ_PEEK_REAR};

  // Per-cycle chance, in percent, that the sender holds back in each phase.
  localparam int unsigned SEND_IDLE_PCT [3] = '{37, 64, 0};

  // One row of the directed table. When typed_in is set the row carries its
  // own expected result; otherwise the predictor supplies it.
  typedef struct packed {
    dq_req_t item;
    logic    typed_in;
    dq_res_t want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 23;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // Every read on the empty queue after reset reports empty.
    '{'{REQ_POP_FRONT,  32'h0000_0000}, 1'b1, '{STAT_EMPTY, 32'h0, 5'd0, 1'b1}},
    '{'{REQ_POP_REAR,   32'hFFFF_FFFF}, 1'b1, '{STAT_EMPTY, 32'h0, 5'd0, 1'b1}},
    '{'{REQ_PEEK_FRONT, 32'h0000_0000}, 1'b1, '{STAT_EMPTY, 32'h0, 5'd0, 1'b1}},
    '{'{REQ_PEEK_REAR,  32'hFFFF_FFFF}, 1'b1, '{STAT_EMPTY, 32'h0, 5'd0, 1'b1}},
    // Unused codes are ignored and report ok with the current count.
    '{'{REQ_UNUSED_LO,  32'hFFFF_FFFF}, 1'b1, '{STAT_OK,    32'h0, 5'd0, 1'b1}},
    '{'{REQ_UNUSED_HI,  32'hFFFF_FFFF}, 1'b1, '{STAT_OK,    32'h0, 5'd0, 1'b1}},
    // Extreme words at both ends; the front push wraps the head pointer.
    '{'{REQ_PUSH_REAR,  32'hFFFF_FFFF}, 1'b1, '{STAT_OK,    32'h0, 5'd1, 1'b0}},
    '{'{REQ_PUSH_FRONT, 32'h0000_0000}, 1'b1, '{STAT_OK,    32'h0, 5'd2, 1'b0}},
    '{'{REQ_PEEK_FRONT, 32'h0000_0000}, 1'b0, '0},
    '{'{REQ_PEEK_REAR,  32'h0000_0000}, 1'b0, '0},
    '{'{REQ_UNUSED_LO,  32'h1234_5678}, 1'b0, '0},
    '{'{REQ_PUSH_FRONT, 32'hA5A5_A5A5}, 1'b0, '0},
    '{'{REQ_PUSH_REAR,  32'h5A5A_5A5A}, 1'b0, '0},
    '{'{REQ_POP_REAR,   32'h0000_0000}, 1'b0, '0},
    '{'{REQ_POP_FRONT,  32'h0000_0000}, 1'b0, '0},
    '{'{REQ_POP_FRONT,  32'h0000_0000}, 1'b0, '0},
    '{'{REQ_POP_REAR,   32'h0000_0000}, 1'b0, '0},
    '{'{REQ_POP_REAR,   32'h0000_0000}, 1'b0, '0},
    // Push at the front, then pop at the rear: the tail wraps downward.
    '{'{REQ_PUSH_FRONT, 32'h8000_0001}, 1'b0, '0},
    '{'{REQ_POP_REAR,   32'h0000_0000}, 1'b0, '0},
    '{'{REQ_PUSH_REAR,  32'h0000_0001}, 1'b0, '0},
    '{'{REQ_PEEK_FRONT, 32'h0000_0000}, 1'b0, '0},
    '{'{REQ_POP_FRONT,  32'h0000_0000}, 1'b0, '0}
  };

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  dq_req_t req;
  logic    done;
  dq_res_t res;

  // Side information that travels with the item on req.
  logic    item_typed_in;
  dq_res_t item_want;

  // Predicted results, oldest first.
  dq_res_t pending_results [$];
  dq_res_t oldest_result;

  int unsigned fail_count;
  int unsigned stall_cycles;

  // Private ring-buffer copy of the queue.
  logic [DATA_WIDTH-1:0] ring [DEPTH];
  logic [PTR_W-1:0]      front_slot;
  logic [PTR_W-1:0]      rear_slot;
  logic [CNT_W-1:0]      fill_level;

  double_ended_queue_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .res_o  (res)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [PTR_W-1:0] slot_after(input logic [PTR_W-1:0] s);
    return (s == PTR_W'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] slot_before(input logic [PTR_W-1:0] s);
    return (s == '0) ? PTR_W'(DEPTH - 1) : s - 1'b1;
  endfunction

  // Carries out one request on the private copy and returns its result.
  // Pushes on a full queue and reads on an empty one leave the copy alone.
  function automatic dq_res_t apply_request(input dq_req_t r);
    dq_res_t out;
    logic    is_full;
    logic    is_void;
    out = '0;
    out.status = STAT_OK;
    is_full = (fill_level == CNT_W'(DEPTH));
    is_void = (fill_level == '0);
    case (r.req_type)
      REQ_PUSH_FRONT: begin
        if (is_full) begin
          out.status = STAT_FULL;
        end else begin
          front_slot = slot_before(front_slot);
          ring[front_slot] = r.push_value[DATA_WIDTH-1:0];
          fill_level = fill_level + 1'b1;
        end
      end
      REQ_PUSH_REAR: begin
        if (is_full) begin
          out.status = STAT_FULL;
        end else begin
          ring[rear_slot] = r.push_value[DATA_WIDTH-1:0];
          rear_slot = slot_after(rear_slot);
          fill_level = fill_level + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (is_void) begin
          out.status = STAT_EMPTY;
        end else begin
          out.read_value = 32'(ring[front_slot]);
          front_slot = slot_after(front_slot);
          fill_level = fill_level - 1'b1;
        end
      end
      REQ_POP_REAR: begin
        if (is_void) begin
          out.status = STAT_EMPTY;
        end else begin
          rear_slot = slot_before(rear_slot);
          out.read_value = 32'(ring[rear_slot]);
          fill_level = fill_level - 1'b1;
        end
      end
      REQ_PEEK_FRONT: begin
        if (is_void) out.status = STAT_EMPTY;
        else out.read_value = 32'(ring[front_slot]);
      end
      REQ_PEEK_REAR: begin
        if (is_void) out.status = STAT_EMPTY;
        else out.read_value = 32'(ring[slot_before(rear_slot)]);
      end
      default: ;
    endcase
    out.entry_total = 5'(fill_level);
    out.is_empty = (fill_level == '0);
    return out;
  endfunction

  // Fill runs mostly push, drain runs mostly pop or peek, mixed runs pick
  // any request. A few unused codes are sprinkled through all of them.
  function automatic dq_req_t random_request(input int unsigned mode);
    dq_req_t     r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) begin
      r.req_type = pick[0] ? REQ_UNUSED_HI : REQ_UNUSED_LO;
    end else if (mode == MODE_FILL) begin
      r.req_type = (pick < 80) ? ALL_REQS[$urandom_range(1)] : ALL_REQS[$urandom_range(5, 2)];
    end else if (mode == MODE_DRAIN) begin
      r.req_type = (pick < 20) ? ALL_REQS[$urandom_range(1)] : ALL_REQS[$urandom_range(5, 2)];
    end else begin
      r.req_type = ALL_REQS[$urandom_range(5)];
    end
    case ($urandom_range(7))
      0: r.push_value = '0;
      1: r.push_value = '1;
      default: r.push_value = $urandom;
    endcase
    return r;
  endfunction

  // Puts an item on the request port at the falling edge and holds it until
  // a rising edge finds busy low. start is left high so that a following
  // item can go out without a gap.
  task automatic send_item(input dq_req_t item, input logic typed_in, input dq_res_t want);
    @(negedge clk);
    start         <= 1'b1;
    req           <= item;
    item_typed_in <= typed_in;
    item_want     <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off_one();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic wait_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checking and prediction share the rising edge. A result always
  // belongs to an item accepted at an earlier edge, so it is checked before
  // the item accepted at this edge adds its own prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("error: result %h arrived with no item outstanding", res);
        end else begin
          oldest_result = pending_results.pop_front();
          if (res.status !== oldest_result.status ||
              res.read_value !== oldest_result.read_value ||
              res.entry_total !== oldest_result.entry_total ||
              res.is_empty !== oldest_result.is_empty) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display({"error: status %h/%h read_value %h/%h entry_total %0d/%0d",
                        " is_empty %b/%b (expected/actual)"},
                       oldest_result.status, res.status,
                       oldest_result.read_value, res.read_value,
                       oldest_result.entry_total, res.entry_total,
                       oldest_result.is_empty, res.is_empty);
          end
        end
      end
      if (start && !busy) begin
        // The predictor runs for typed rows too, so its state stays in step.
        oldest_result = apply_request(req);
        pending_results.push_back(item_typed_in ? item_want : oldest_result);
      end
    end
  end

  // Watchdog: a long run of edges with neither an accepted item nor a
  // result means the block has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || done) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned items_sent;
    int unsigned run_left;
    int unsigned run_mode;
    dq_req_t     item;
    rst_n         = 1'b0;
    start         = 1'b0;
    req           = '0;
    item_typed_in = 1'b0;
    item_want     = '0;
    fail_count    = 0;
    stall_cycles  = 0;
    front_slot    = '0;
    rear_slot     = '0;
    fill_level    = '0;
    items_sent    = 0;
    run_left      = 0;
    run_mode      = MODE_MIX;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table, sent back to back.
    for (int i = 0; i < DIR_ROWS; i++)
      send_item(DIRECTED[i].item, DIRECTED[i].typed_in, DIRECTED[i].want);

    // Let the pipeline run dry once before the random part.
    wait_until_drained();

    // Random part in three phases of sender idling. Every item sent counts
    // toward the total, unused codes included.
    for (int phase = 0; phase < 3; phase++) begin
      while (items_sent < (phase + 1) * RANDOM_ITEMS / 3) begin
        if (run_left == 0) begin
          run_left = $urandom_range(60, 20);
          run_mode = $urandom_range(MODE_MIX);
        end
        while ($urandom_range(99) < SEND_IDLE_PCT[phase]) hold_off_one();
        item = random_request(run_mode);
        send_item(item, 1'b0, '0);
        items_sent++;
        run_left--;
      end
      wait_until_drained();
    end

    // Give any stray result time to show up before deciding.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) fail_count++;

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dq_pkg.sv
rtl/dq_ctrl.sv
rtl/dq_datapath.sv
rtl/double_ended_queue_core.sv
sim/testbench.sv
